// ----- src/assert_macros.svh -----
// assertion macros for the step core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define EORS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define EORS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ----- src/eors_pkg.sv -----
// constants, codes and types of the step core
`default_nettype none

package eors_pkg;

    localparam int MEM_WORDS = 65536;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int WORD_W    = 32;
    localparam int PW_W      = 17;

    localparam int OPC_LSB = 22;
    localparam int RA_LSB  = 19;
    localparam int RB_LSB  = 16;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_NAND = 3'd1,
        OP_LW   = 3'd2,
        OP_SW   = 3'd3,
        OP_BEQ  = 3'd4,
        OP_JALR = 3'd5,
        OP_HALT = 3'd6,
        OP_NOOP = 3'd7
    } opcode_t;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_EXEC = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [2:0] ST_EXEC    = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_PAST    = 3'd2;
    localparam logic [2:0] ST_STOPPED = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    typedef struct packed {
        logic [2:0]           status;
        logic [15:0]          next_pc;
        logic                 rw_valid;
        logic [REG_IDX_W-1:0] rw_index;
        logic [WORD_W-1:0]    rw_value;
        logic                 mw_valid;
        logic [15:0]          mw_address;
        logic [WORD_W-1:0]    mw_value;
        logic [WORD_W-1:0]    read_data;
        logic [WORD_W-1:0]    exec_count;
    } result_t;

endpackage

`default_nettype wire

// ----- src/eors_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module eors_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/eight_opcode_risc_step_core.sv -----
// eight-register step core: sequencer around program memory and register file rams
// load, read, spare and non-running execute: result made in decode; no new request until back in idle
// running execute: decode, then execute gives the result (lw: execute, then memory)
// fetch, register read and data read each go through a registered ram read; a stalled result holds the core
// reset clears pc, halt flag, count, program_words and register valid bits
// memory holds no reset value and is defined only where loaded or stored; no clearing pass
`default_nettype none
`include "assert_macros.svh"

module eight_opcode_risc_step_core
    import eors_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_write_enable,
    input  wire logic [PW_W-1:0]    cfg_write_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         command,
    input  wire logic [15:0]        address,
    input  wire logic signed [31:0] data,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              status,
    output logic [15:0]             next_pc,
    output logic                    reg_write_valid,
    output logic [2:0]              reg_write_index,
    output logic signed [31:0]      reg_write_value,
    output logic                    mem_write_valid,
    output logic [15:0]             mem_write_address,
    output logic signed [31:0]      mem_write_value,
    output logic signed [31:0]      read_data,
    output logic [31:0]             executed_count
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_EXE  = 5'b00100,
        S_MEM  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [1:0]            cmd_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [WORD_W-1:0]     data_reg;
    logic [WORD_W-1:0]     insn_reg;
    logic                  va_ok_reg, vb_ok_reg;
    logic [ADDR_W-1:0]     pc_reg, pc_next;
    logic                  halted_reg, halted_next;
    logic [WORD_W-1:0]     cnt_reg, cnt_next;
    logic [REG_COUNT-1:0]  rf_valid_reg;
    logic [PW_W-1:0]       prog_words_reg;
    result_t               res_reg;
    result_t               out_reg;
    logic                  out_valid_reg;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [WORD_W-1:0]     mem_wdata, mem_rdata;
    logic                  rf_we;
    logic [REG_IDX_W-1:0]  rf_waddr, rf_raddr_a, rf_raddr_b;
    logic [WORD_W-1:0]     rf_wdata, rf_qa, rf_qb;

    logic                  finish, out_free, out_load;
    result_t               res;

    opcode_t               opc;
    logic [REG_IDX_W-1:0]  ra, rb, rdst;
    logic [WORD_W-1:0]     va, vb;
    logic [ADDR_W-1:0]     imm_w, seq, target, ea;

    eors_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    eors_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr_a),
        .rdata (rf_qa)
    );

    eors_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr_b),
        .rdata (rf_qb)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // decode of the held instruction
    assign opc    = opcode_t'(insn_reg[OPC_LSB +: 3]);
    assign ra     = insn_reg[RA_LSB +: REG_IDX_W];
    assign rb     = insn_reg[RB_LSB +: REG_IDX_W];
    assign rdst   = insn_reg[REG_IDX_W-1:0];
    assign va     = va_ok_reg ? rf_qa : '0;
    assign vb     = vb_ok_reg ? rf_qb : '0;
    assign imm_w  = insn_reg[ADDR_W-1:0];
    assign seq    = pc_reg + ADDR_W'(1);
    assign target = seq + imm_w;
    assign ea     = va[ADDR_W-1:0] + imm_w;

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        halted_next = halted_reg;
        cnt_next    = cnt_reg;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = data_reg;
        mem_raddr   = pc_reg;
        rf_we       = 1'b0;
        rf_waddr    = rdst;
        rf_wdata    = '0;
        rf_raddr_a  = mem_rdata[RA_LSB +: REG_IDX_W];
        rf_raddr_b  = mem_rdata[RB_LSB +: REG_IDX_W];
        finish      = 1'b0;
        res         = '0;
        res.status     = ST_DONE;
        res.next_pc    = 16'(pc_reg);
        res.exec_count = cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (command == CMD_READ)
                begin
                    mem_raddr = address[ADDR_W-1:0];
                end
                if (in_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (cmd_reg)
                    CMD_LOAD:
                    begin
                        mem_we         = 1'b1;
                        res.mw_valid   = 1'b1;
                        res.mw_address = 16'(addr_reg);
                        res.mw_value   = data_reg;
                        finish         = 1'b1;
                    end
                    CMD_READ:
                    begin
                        res.read_data = mem_rdata;
                        finish        = 1'b1;
                    end
                    CMD_EXEC:
                    begin
                        if (halted_reg)
                        begin
                            res.status = ST_STOPPED;
                            finish     = 1'b1;
                        end
                        else if (PW_W'(pc_reg) >= prog_words_reg)
                        begin
                            res.status = ST_PAST;
                            finish     = 1'b1;
                        end
                        else
                        begin
                            state_next = S_EXE;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_EXE:
            begin
                cnt_next   = (cnt_reg == '1) ? cnt_reg : cnt_reg + WORD_W'(1);
                pc_next    = seq;
                res.status = ST_EXEC;
                finish     = 1'b1;
                case (opc)
                    OP_ADD, OP_NAND:
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = rdst;
                        rf_wdata = (opc == OP_ADD) ? (va + vb) : ~(va & vb);
                    end
                    OP_LW:
                    begin
                        mem_raddr  = ea;
                        state_next = S_MEM;
                        finish     = 1'b0;
                    end
                    OP_SW:
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = ea;
                        mem_wdata      = vb;
                        res.mw_valid   = 1'b1;
                        res.mw_address = 16'(ea);
                        res.mw_value   = vb;
                    end
                    OP_BEQ:
                    begin
                        if (va == vb)
                        begin
                            pc_next = target;
                        end
                    end
                    OP_JALR:
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = rb;
                        rf_wdata = WORD_W'(seq);
                        pc_next  = (ra == rb) ? seq : va[ADDR_W-1:0];
                    end
                    OP_HALT:
                    begin
                        halted_next = 1'b1;
                        res.status  = ST_HALT;
                    end
                    default:
                    begin
                    end
                endcase
                res.rw_valid   = rf_we;
                res.rw_index   = rf_we ? rf_waddr : '0;
                res.rw_value   = rf_wdata;
                res.next_pc    = 16'(pc_next);
                res.exec_count = cnt_next;
            end
            S_MEM:
            begin
                rf_we        = 1'b1;
                rf_waddr     = rb;
                rf_wdata     = mem_rdata;
                res.status   = ST_EXEC;
                res.rw_valid = 1'b1;
                res.rw_index = rb;
                res.rw_value = mem_rdata;
                finish       = 1'b1;
            end
            S_OUT:
            begin
                res    = res_reg;
                finish = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_load = finish && out_free;
        if (finish)
        begin
            state_next = out_free ? S_IDLE : S_OUT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pc_reg         <= '0;
            halted_reg     <= 1'b0;
            cnt_reg        <= '0;
            rf_valid_reg   <= '0;
            prog_words_reg <= '0;
            out_valid_reg  <= 1'b0;
            va_ok_reg      <= 1'b0;
            vb_ok_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            halted_reg <= halted_next;
            cnt_reg    <= cnt_next;
            va_ok_reg  <= rf_valid_reg[rf_raddr_a];
            vb_ok_reg  <= rf_valid_reg[rf_raddr_b];
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            if (cfg_write_enable)
            begin
                prog_words_reg <= cfg_write_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg  <= command;
            addr_reg <= address[ADDR_W-1:0];
            data_reg <= data;
        end
        if (state_reg == S_DEC)
        begin
            insn_reg <= mem_rdata;
        end
        if (finish)
        begin
            res_reg <= res;
        end
        if (out_load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_reg.status;
    assign next_pc           = out_reg.next_pc;
    assign reg_write_valid   = out_reg.rw_valid;
    assign reg_write_index   = out_reg.rw_index;
    assign reg_write_value   = $signed(out_reg.rw_value);
    assign mem_write_valid   = out_reg.mw_valid;
    assign mem_write_address = out_reg.mw_address;
    assign mem_write_value   = $signed(out_reg.mw_value);
    assign read_data         = $signed(out_reg.read_data);
    assign executed_count    = out_reg.exec_count;

    `EORS_ASSERT_NEXT(a_accept_dec, (in_valid && !in_stall), (state_reg == S_DEC), "request not decoded")
    `EORS_ASSERT_NEXT(a_halt_sticky, halted_reg, halted_reg, "halt flag dropped")
    `EORS_ASSERT(a_count_mono, (cnt_reg >= $past(cnt_reg)), "instruction count went down")
    `EORS_ASSERT(a_pc_in_exe, ($stable(pc_reg) || $past(state_reg) == S_EXE), "pc moved outside execute")
    `EORS_ASSERT(a_out_hold, (!out_valid_reg || state_reg != S_OUT || out_stall || $past(out_stall)), "result held while output free")

endmodule

`default_nettype wire

// ----- test/eors_step_checker.sv -----
// checker for the step core: tracks requests, predicts each result and compares it
module eors_step_checker
    import eors_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_enable,
    input  wire logic [16:0] cfg_write_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] address,
    input  wire logic [31:0] data,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [2:0]  status,
    input  wire logic [15:0] next_pc,
    input  wire logic        reg_write_valid,
    input  wire logic [2:0]  reg_write_index,
    input  wire logic [31:0] reg_write_value,
    input  wire logic        mem_write_valid,
    input  wire logic [15:0] mem_write_address,
    input  wire logic [31:0] mem_write_value,
    input  wire logic [31:0] read_data,
    input  wire logic [31:0] executed_count,
    output int               mismatches,
    output int               outstanding,
    output logic             exec_ready,
    output logic             fetch_missing,
    output logic [15:0]      missing_address,
    output logic [15:0]      pc_now
);

    logic [31:0] mem_img [0:65535];
    bit          written [0:65535];
    logic [31:0] regs [0:7];
    logic [15:0] pc;
    logic        halted;
    logic [31:0] instr_count;
    logic [16:0] program_words;
    result_t     awaited_results[$];

    function automatic result_t execute_request(input logic [1:0] cmd,
                                                input logic [15:0] addr,
                                                input logic [31:0] word);
        result_t     r;
        logic [31:0] insn;
        logic [31:0] va;
        logic [31:0] vb;
        logic [15:0] seq;
        logic [15:0] npc;
        logic [15:0] ea;
        logic [2:0]  ra;
        logic [2:0]  rb;
        opcode_t     op;
        r = '0;
        r.status = ST_DONE;
        if (cmd == CMD_LOAD)
        begin
            mem_img[addr] = word;
            written[addr] = 1'b1;
            r.mw_valid = 1'b1;
            r.mw_address = addr;
            r.mw_value = word;
        end
        else if (cmd == CMD_READ)
        begin
            r.read_data = mem_img[addr];
        end
        else if (cmd == CMD_EXEC)
        begin
            if (halted)
                r.status = ST_STOPPED;
            else if ({1'b0, pc} >= program_words)
                r.status = ST_PAST;
            else
            begin
                insn = mem_img[pc];
                op = opcode_t'(insn[24:22]);
                ra = insn[21:19];
                rb = insn[18:16];
                va = regs[ra];
                vb = regs[rb];
                seq = pc + 16'd1;
                npc = seq;
                ea = va[15:0] + insn[15:0];
                if (instr_count != '1)
                    instr_count++;
                r.status = ST_EXEC;
                case (op)
                    OP_ADD, OP_NAND:
                    begin
                        r.rw_valid = 1'b1;
                        r.rw_index = insn[2:0];
                        r.rw_value = (op == OP_ADD) ? va + vb : ~(va & vb);
                    end
                    OP_LW:
                    begin
                        r.rw_valid = 1'b1;
                        r.rw_index = rb;
                        r.rw_value = mem_img[ea];
                    end
                    OP_SW:
                    begin
                        mem_img[ea] = vb;
                        written[ea] = 1'b1;
                        r.mw_valid = 1'b1;
                        r.mw_address = ea;
                        r.mw_value = vb;
                    end
                    OP_BEQ:
                    begin
                        if (va == vb)
                            npc = seq + insn[15:0];
                    end
                    OP_JALR:
                    begin
                        // link first, so a shared register jumps to the link
                        regs[rb] = {16'd0, seq};
                        npc = regs[ra][15:0];
                        r.rw_valid = 1'b1;
                        r.rw_index = rb;
                        r.rw_value = {16'd0, seq};
                    end
                    OP_HALT:
                    begin
                        halted = 1'b1;
                        r.status = ST_HALT;
                    end
                    default:
                    begin
                    end
                endcase
                if (r.rw_valid)
                    regs[r.rw_index] = r.rw_value;
                pc = npc;
            end
        end
        r.next_pc = pc;
        r.exec_count = instr_count;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t     want;
        logic [31:0] fetched;
        logic [15:0] ea;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                regs[i] = '0;
            pc = '0;
            halted = 1'b0;
            instr_count = '0;
            program_words = '0;
            awaited_results.delete();
            mismatches = 0;
            outstanding = 0;
            exec_ready = 1'b1;
            fetch_missing = 1'b0;
            missing_address = '0;
            pc_now = '0;
        end
        else
        begin
            if (cfg_write_enable)
                program_words = cfg_write_data;
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with no request waiting");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    outstanding--;
                    compare_field("status", want.status, status);
                    compare_field("next_pc", want.next_pc, next_pc);
                    compare_field("reg_write_valid", want.rw_valid, reg_write_valid);
                    compare_field("reg_write_index", want.rw_index, reg_write_index);
                    compare_field("reg_write_value", want.rw_value, reg_write_value);
                    compare_field("mem_write_valid", want.mw_valid, mem_write_valid);
                    compare_field("mem_write_address", want.mw_address, mem_write_address);
                    compare_field("mem_write_value", want.mw_value, mem_write_value);
                    compare_field("read_data", want.read_data, read_data);
                    compare_field("executed_count", want.exec_count, executed_count);
                end
            end
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(execute_request(command, address, data));
                outstanding++;
            end
            // can the next execute run without touching unwritten memory
            exec_ready = 1'b1;
            fetch_missing = 1'b0;
            missing_address = pc;
            if (!halted && {1'b0, pc} < program_words)
            begin
                if (!written[pc])
                begin
                    exec_ready = 1'b0;
                    fetch_missing = 1'b1;
                end
                else
                begin
                    fetched = mem_img[pc];
                    if (opcode_t'(fetched[24:22]) == OP_LW)
                    begin
                        ea = regs[fetched[21:19]][15:0] + fetched[15:0];
                        if (!written[ea])
                        begin
                            exec_ready = 1'b0;
                            missing_address = ea;
                        end
                    end
                end
            end
            pc_now = pc;
        end
    end

endmodule

// ----- test/eight_opcode_risc_step_core_tb.sv -----
// testbench top for the step core: clock, reset, request stimulus and verdict
module eight_opcode_risc_step_core_tb
    import eors_pkg::*;
;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_write_enable;
    logic [PW_W-1:0]    cfg_write_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         command;
    logic [15:0]        address;
    logic signed [31:0] data;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic [15:0]        next_pc;
    logic               reg_write_valid;
    logic [2:0]         reg_write_index;
    logic signed [31:0] reg_write_value;
    logic               mem_write_valid;
    logic [15:0]        mem_write_address;
    logic signed [31:0] mem_write_value;
    logic signed [31:0] read_data;
    logic [31:0]        executed_count;

    int                 mismatches;
    int                 outstanding;
    logic               exec_ready;
    logic               fetch_missing;
    logic [15:0]        missing_address;
    logic [15:0]        pc_now;

    int                 gap_pct = 0;
    int                 stall_pct = 0;
    bit                 calm = 1'b0;
    logic [15:0]        loaded_addrs[$];

    eight_opcode_risc_step_core DUT (.*);

    eors_step_checker step_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("eight_opcode_risc_step_core_tb: errors");
        $finish;
    end

    function automatic logic [31:0] build_insn(input opcode_t op, input logic [2:0] ra,
                                               input logic [2:0] rb, input logic [15:0] low);
        return {7'd0, op, ra, rb, low};
    endfunction

    function automatic logic [31:0] random_instruction();
        opcode_t     op;
        logic [15:0] low;
        op = opcode_t'($urandom_range(0, 7));
        // halt is sticky, so it is kept for the end of the run
        if (op == OP_HALT)
            op = OP_BEQ;
        if ($urandom_range(0, 3) != 0)
            low = 16'($urandom_range(0, 16)) - 16'd8;
        else
            low = 16'($urandom());
        return {7'($urandom()), op, 3'($urandom()), 3'($urandom()), low};
    endfunction

    function automatic logic [31:0] operand_word();
        if ($urandom_range(0, 9) < 7)
            return 32'($urandom_range(0, 40));
        return $urandom();
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] cmd, input logic [15:0] addr,
                                input logic [31:0] word);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        address <= addr;
        data <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd == CMD_LOAD)
            loaded_addrs.push_back(addr);
        @(negedge clk);
    endtask

    task automatic issue_execute();
        while (!exec_ready)
        begin
            if (fetch_missing)
                send_request(CMD_LOAD, missing_address, random_instruction());
            else
                send_request(CMD_LOAD, missing_address, operand_word());
        end
        send_request(CMD_EXEC, 16'($urandom()), $urandom());
    endtask

    task automatic settle_and_configure(input logic [PW_W-1:0] words);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data <= words;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            issue_execute();
        else if (pick < 80)
            send_request(CMD_LOAD,
                         ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 63))
                                                    : 16'($urandom()),
                         $urandom_range(0, 1) ? random_instruction() : $urandom());
        else if (pick < 94)
            send_request(CMD_READ, loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)],
                         $urandom());
        else
            send_request(CMD_SPARE, 16'($urandom()), $urandom());
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic [PW_W-1:0] words;
        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        command = CMD_LOAD;
        address = '0;
        data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty program, unused command, then a short program
        send_request(CMD_EXEC, 16'd0, 32'd0);
        send_request(CMD_SPARE, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(CMD_LOAD, 16'd0, build_insn(OP_LW, 3'd0, 3'd1, 16'd100));
        send_request(CMD_LOAD, 16'd1, build_insn(OP_LW, 3'd0, 3'd2, 16'hFFFF));
        send_request(CMD_LOAD, 16'd2, build_insn(OP_ADD, 3'd1, 3'd2, 16'd3));
        send_request(CMD_LOAD, 16'd3, build_insn(OP_NAND, 3'd1, 3'd2, 16'd4));
        send_request(CMD_LOAD, 16'd4, build_insn(OP_SW, 3'd3, 3'd1, 16'd200));
        send_request(CMD_LOAD, 16'd5, build_insn(OP_BEQ, 3'd1, 3'd2, 16'd5));
        send_request(CMD_LOAD, 16'd6, build_insn(OP_BEQ, 3'd0, 3'd0, 16'd2));
        send_request(CMD_LOAD, 16'd9, build_insn(OP_JALR, 3'd5, 3'd5, 16'd0));
        send_request(CMD_LOAD, 16'd10, 32'hFE00_0000 | build_insn(OP_NOOP, 3'd7, 3'd7, 16'hFFFF));
        send_request(CMD_LOAD, 16'd11, build_insn(OP_JALR, 3'd3, 3'd6, 16'd0));
        send_request(CMD_LOAD, 16'd100, 32'h7FFF_FFFF);
        send_request(CMD_LOAD, 16'hFFFF, 32'h8000_0000);
        send_request(CMD_READ, 16'hFFFF, 32'd0);
        settle_and_configure(17'd65536);
        repeat (11) issue_execute();
        send_request(CMD_READ, 16'd199, 32'd0);

        for (int n = 0; n < 450; n++)
        begin
            if (n % 50 == 0)
            begin
                case ((n / 50) % 6)
                    0: words = 17'd65536;
                    1: words = 17'($urandom_range(2, 48));
                    2: words = 17'd65536;
                    3: words = 17'd0;
                    4: words = 17'($urandom_range(0, 65536));
                    default: words = 17'd65535;
                endcase
                if (n >= 350)
                    words = 17'd65536;
                settle_and_configure(words);
                gap_pct = 15 * $urandom_range(0, 2);
                stall_pct = 15 * $urandom_range(0, 2);
            end
            calm = (n >= 390);
            random_request();
        end

        // halt, then requests against a stopped core
        settle_and_configure(17'd65536);
        send_request(CMD_LOAD, pc_now,
                     {7'($urandom()), 25'(build_insn(OP_HALT, 3'($urandom()), 3'($urandom()),
                                                     16'($urandom())))});
        issue_execute();
        issue_execute();
        repeat (15) random_request();

        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        if (mismatches == 0)
            $display("eight_opcode_risc_step_core_tb: clean");
        else
            $display("eight_opcode_risc_step_core_tb: errors");
        $finish;
    end

endmodule

// ----- eight_opcode_risc_step_core.f -----
+incdir+src
src/eors_pkg.sv
src/eors_ram.sv
src/eight_opcode_risc_step_core.sv
test/eors_step_checker.sv
test/eight_opcode_risc_step_core_tb.sv
